// ===== rtl/first_fit_coalescing_allocator_assert.svh =====
// Assertion macros for the first-fit allocator.
// Used by first_fit_coalescing_allocator.sv; expects clk and rst_n in scope.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH

// property must hold at every edge out of reset
`define FFCA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define FFCA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/ffca_pkg.sv =====
// Shared types and constants for the first-fit allocator.
// No dependencies; imported by ffca_cell and the top level.
`default_nettype none

package ffca_pkg;

    localparam logic [14:0] POOL_CAPACITY = 15'd16384;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_DOUBLE = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // token modes
    localparam logic [1:0] MD_SEARCH = 2'd0;
    localparam logic [1:0] MD_REMOVE = 2'd1;
    localparam logic [1:0] MD_INSERT = 2'd2;
    localparam logic [1:0] MD_PASS   = 2'd3;

    typedef struct packed {
        logic        op;
        logic [13:0] range_start;
        logic [14:0] range_length;
    } cmd_t;

    typedef struct packed {
        logic [13:0] granted_start;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic        vld;
        logic [13:0] start;
        logic [14:0] len;
    } ent_t;

    // request travelling down the chain; rs/rl double as the insert carry
    typedef struct packed {
        logic        vld;
        logic [1:0]  mode;
        logic        op;
        logic [13:0] rs;
        logic [14:0] rl;
        logic [13:0] granted;
        logic [1:0]  status;
    } tok_t;

endpackage

`default_nettype wire

// ===== rtl/ffca_cell.sv =====
// One extent cell of the allocator chain.
// Depends on ffca_pkg.
`default_nettype none

module ffca_cell
    import ffca_pkg::*;
#(
    parameter bit HEAD = 1'b0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic        cfg_load,
    input  wire logic [14:0] pool,
    input  wire logic        full,
    input  wire tok_t        tok_in,
    input  wire ent_t        nxt,
    output tok_t             tok_out,
    output ent_t             ent
);

    ent_t        ent_reg, ent_next;
    tok_t        tok_reg, tok_next;
    logic [14:0] end_pos;
    logic [14:0] merged;

    assign end_pos = {1'b0, ent_reg.start} + ent_reg.len;
    assign merged  = ent_reg.len + tok_in.rl;

    always_comb
    begin
        ent_next = ent_reg;
        tok_next = tok_in;
        if (tok_in.vld)
        begin
            unique case (tok_in.mode)
                MD_SEARCH:
                begin
                    if (!ent_reg.vld)
                    begin
                        tok_next.mode = MD_PASS;
                        if (tok_in.op == OP_ALLOC)
                            tok_next.status = ST_NOFIT;
                        else
                            ent_next = '{vld: 1'b1, start: tok_in.rs, len: tok_in.rl};
                    end
                    else if (tok_in.op == OP_ALLOC)
                    begin
                        if (ent_reg.len == tok_in.rl)
                        begin
                            tok_next.granted = ent_reg.start;
                            tok_next.mode    = MD_REMOVE;
                            ent_next         = nxt;
                        end
                        else if (ent_reg.len > tok_in.rl)
                        begin
                            tok_next.granted = ent_reg.start;
                            tok_next.mode    = MD_PASS;
                            ent_next.start   = ent_reg.start + tok_in.rl[13:0];
                            ent_next.len     = ent_reg.len - tok_in.rl;
                        end
                    end
                    else if (end_pos == {1'b0, tok_in.rs})
                    begin
                        // merge onto this extent, maybe absorb the next one
                        tok_next.mode = MD_PASS;
                        ent_next.len  = merged;
                        if (nxt.vld && ({1'b0, nxt.start} == end_pos + tok_in.rl))
                        begin
                            ent_next.len  = merged + nxt.len;
                            tok_next.mode = MD_REMOVE;
                        end
                    end
                    else if (ent_reg.start > tok_in.rs)
                    begin
                        tok_next.mode = MD_PASS;
                        if ({1'b0, tok_in.rs} + tok_in.rl == {1'b0, ent_reg.start})
                        begin
                            ent_next.start = tok_in.rs;
                            ent_next.len   = merged;
                        end
                        else if (full)
                            tok_next.status = ST_FULL;
                        else
                        begin
                            ent_next      = '{vld: 1'b1, start: tok_in.rs, len: tok_in.rl};
                            tok_next.rs   = ent_reg.start;
                            tok_next.rl   = ent_reg.len;
                            tok_next.mode = MD_INSERT;
                        end
                    end
                    else if (ent_reg.start == tok_in.rs)
                    begin
                        tok_next.mode   = MD_PASS;
                        tok_next.status = ST_DOUBLE;
                    end
                end
                MD_REMOVE:
                    ent_next = nxt;
                MD_INSERT:
                begin
                    ent_next = '{vld: 1'b1, start: tok_in.rs, len: tok_in.rl};
                    if (ent_reg.vld)
                    begin
                        tok_next.rs = ent_reg.start;
                        tok_next.rl = ent_reg.len;
                    end
                    else
                        tok_next.mode = MD_PASS;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg     <= '{vld: HEAD, start: 14'd0, len: POOL_CAPACITY};
            tok_reg     <= '0;
        end
        else if (cfg_load)
        begin
            ent_reg <= '{vld: HEAD && (pool != 15'd0), start: 14'd0, len: pool};
        end
        else if (adv)
        begin
            ent_reg <= ent_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign ent     = ent_reg;

endmodule

`default_nettype wire

// ===== rtl/first_fit_coalescing_allocator.sv =====
// Top level of the first-fit coalescing slot allocator.
// Depends on ffca_pkg, ffca_cell and first_fit_coalescing_allocator_assert.svh.
//
//  channel | signals                     | direction | payload
//  cmd     | cmd_valid, cmd_stall, cmd   | in        | op, range_start, range_length
//  rsp     | rsp_valid, rsp_stall, rsp   | out       | granted_start, status
//  cfg     | cfg_we, cfg_wdata           | in        | pool_size (write only)
//
// One transaction at a time: a request passes the entry register, then the token
// walks the extent chain one cell per cycle while the chain is not frozen, then
// the response register. cmd_stall is high while a request is in the chain; a
// finished response may wait in rsp while the next request enters.
// A stalled response that is still waiting when the next token reaches the chain
// end freezes the whole chain until it is taken.
// Reset (rst_n, asynchronous) gives one free extent covering 16384 slots.
`default_nettype none

module first_fit_coalescing_allocator
    import ffca_pkg::*;
#(
    parameter int MAX_EXTENTS = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata
);

    `include "first_fit_coalescing_allocator_assert.svh"

    // pool size register, saturated at capacity
    logic [14:0] pool_reg;

    // chain: tok[0] is the entry register, tok[i+1] is cell i's output
    tok_t tok [MAX_EXTENTS+1];
    ent_t ent [MAX_EXTENTS];
    logic [MAX_EXTENTS:0]   tok_vlds;
    logic [MAX_EXTENTS-1:0] ent_vlds;

    tok_t tok0_reg, tok0_next, tok_new;
    logic busy_reg;
    logic adv;
    logic accept;
    logic full;
    logic done;

    logic [14:0] rs_ext;
    logic [14:0] room;

    logic rsp_vld_reg;
    rsp_t rsp_reg;
    rsp_t rsp_fin;

    assign accept    = cmd_valid && !busy_reg;
    assign cmd_stall = busy_reg;
    assign done      = tok[MAX_EXTENTS].vld;
    // freeze when the finished token cannot be handed to the response register
    assign adv       = !(done && rsp_vld_reg && rsp_stall);
    assign full      = ent[MAX_EXTENTS-1].vld;

    // entry: clip frees to the pool and short-cut empty ones
    assign rs_ext = {1'b0, cmd.range_start};
    assign room   = pool_reg - rs_ext;

    always_comb
    begin
        tok_new         = '0;
        tok_new.vld     = 1'b1;
        tok_new.op      = cmd.op;
        tok_new.rs      = cmd.range_start;
        tok_new.rl      = cmd.range_length;
        tok_new.mode    = MD_SEARCH;
        tok_new.status  = ST_OK;
        if (cmd.op == OP_FREE)
        begin
            if (rs_ext >= pool_reg || cmd.range_length == 15'd0)
                tok_new.mode = MD_PASS;
            else if (cmd.range_length > room)
                tok_new.rl = room;
        end
    end

    always_comb
    begin
        tok0_next = tok0_reg;
        if (accept)
            tok0_next = tok_new;
        else if (adv)
            tok0_next.vld = 1'b0;
    end

    assign tok[0] = tok0_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EXTENTS; gi++)
        begin : g_cell
            ent_t nxt;
            if (gi == MAX_EXTENTS - 1)
            begin : g_last
                assign nxt = '0;
            end
            else
            begin : g_mid
                assign nxt = ent[gi+1];
            end

            ffca_cell #(
                .HEAD (gi == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .cfg_load (cfg_we),
                .pool     ((cfg_wdata > POOL_CAPACITY) ? POOL_CAPACITY : cfg_wdata),
                .full     (full),
                .tok_in   (tok[gi]),
                .nxt      (nxt),
                .tok_out  (tok[gi+1]),
                .ent      (ent[gi])
            );

            assign ent_vlds[gi] = ent[gi].vld;
        end

        for (gi = 0; gi <= MAX_EXTENTS; gi++)
        begin : g_tv
            assign tok_vlds[gi] = tok[gi].vld;
        end
    endgenerate

    // a token still searching at the end ran off the table
    always_comb
    begin
        rsp_fin.granted_start = tok[MAX_EXTENTS].granted;
        rsp_fin.status        = tok[MAX_EXTENTS].status;
        if (tok[MAX_EXTENTS].mode == MD_SEARCH)
            rsp_fin.status = (tok[MAX_EXTENTS].op == OP_FREE) ? ST_FULL : ST_NOFIT;
        if (rsp_fin.status != ST_OK)
            rsp_fin.granted_start = 14'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg    <= POOL_CAPACITY;
            tok0_reg    <= '0;
            busy_reg    <= 1'b0;
            rsp_vld_reg <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                pool_reg <= (cfg_wdata > POOL_CAPACITY) ? POOL_CAPACITY : cfg_wdata;
            tok0_reg <= tok0_next;
            if (accept)
                busy_reg <= 1'b1;
            else if (done && adv)
                busy_reg <= 1'b0;
            if (done && adv)
            begin
                rsp_vld_reg <= 1'b1;
                rsp_reg     <= rsp_fin;
            end
            else if (!rsp_stall)
                rsp_vld_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    `FFCA_CHECK(a_one_token, $onehot0(tok_vlds), "more than one transaction in chain")
    `FFCA_CHECK(a_busy_cover, (tok_vlds != '0) |-> busy_reg, "token in chain while idle")
    `FFCA_NEVER(a_prefix, (ent_vlds & (ent_vlds + 1'b1)) != '0, "free extents not contiguous")
    `FFCA_CHECK(a_frozen, !adv |=> $stable(tok_vlds), "chain moved while frozen")

endmodule

`default_nettype wire
